// ===== rtl/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants for the periodic task dispatcher
// Holds the operation and result codes, the task entry layout and the
// controller states.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // Default number of task slots
  localparam int unsigned MaxTasksDefault = 16;

  // Run length after reset
  localparam logic [31:0] RunLengthReset = 32'd2000;

  // Stream word widths
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 40;

  // Input operation codes (s_axis_tuser)
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // Result kinds (m_axis_tuser)
  typedef enum logic [1:0] {
    KIND_LOADED   = 2'd0,
    KIND_IDLE     = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_FINISHED = 2'd3
  } kind_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_BEST,
    ST_REMAINDER,
    ST_SCAN_PICK,
    ST_RESULT
  } state_e;

  // One task table entry as stored in the task memory
  typedef struct packed {
    logic [31:0] due;
    logic [15:0] period;
    logic [15:0] duration;
    logic [15:0] prio;
  } entry_t;

  // 32-bit add that sticks at all ones on overflow
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

// ===== rtl/periodic_task_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_core: non-preemptive periodic task dispatcher
// Keeps a table of periodic tasks in a single-port-write task memory and,
// on each step, dispatches the highest-priority ready task (ties broken by
// tie_pick modulo the tie count), idles one tick, or reports the run done.
// ----------------------------------------------------------------------------
// A load or a finished step goes straight to the result state; an idle tick takes one
// scan of the task memory, and a dispatch takes two task memory scans with a bit-serial
// remainder unit between them.
// One item in work at a time; input ready returns as the result enters the output
// register, so a new item waits for the last one's result and for any output stall.
// Reset clears time, valid bits and run_length (2000); task memory is not cleared.
module periodic_task_dispatcher_core
  import ptd_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasksDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // task_slot[3:0], period[19:4], duration[35:20], priority_req[51:36],
  // tie_pick[67:52], zero fill [71:68]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op[0]
  input  logic [0:0]          s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // chosen_slot[3:0], start_time[35:4], zero fill [39:36]
  output logic [OutDataW-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]          m_axis_tuser,
  // run_length write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned SlotW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_TASKS + 1);
  localparam logic [CntW-1:0]  NumSlots = CntW'(MAX_TASKS);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_TASKS - 1);

  // Input field unpacking
  logic [3:0]  in_slot;
  logic [15:0] in_period;
  logic [15:0] in_duration;
  logic [15:0] in_prio;
  logic [15:0] in_tie;
  logic        in_acc;

  assign in_slot     = s_axis_tdata[3:0];
  assign in_period   = s_axis_tdata[19:4];
  assign in_duration = s_axis_tdata[35:20];
  assign in_prio     = s_axis_tdata[51:36];
  assign in_tie      = s_axis_tdata[67:52];
  assign in_acc      = s_axis_tvalid && s_axis_tready;

  // Registers
  state_e               state_q, state_d;
  logic [31:0]          run_len_q;
  logic [31:0]          cur_time_q, cur_time_d;
  logic [MAX_TASKS-1:0] valid_q, valid_d;
  logic [31:0]          now_q, now_d;
  logic [CntW-1:0]      iss_q, iss_d;
  logic                 rd_vld_q;
  logic [SlotW-1:0]     rd_idx_q;
  entry_t               rd_data_q;
  logic                 found_q, found_d;
  logic [15:0]          best_q, best_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      rem_q, rem_d;
  logic [15:0]          div_q, div_d;
  logic [3:0]           bit_q, bit_d;
  logic [CntW-1:0]      seen_q, seen_d;
  kind_e                res_kind_q, res_kind_d;
  logic [3:0]           res_slot_q, res_slot_d;
  logic                 m_valid_q, m_valid_d;
  kind_e                m_kind_q, m_kind_d;
  logic [3:0]           m_slot_q, m_slot_d;
  logic [31:0]          m_start_q, m_start_d;

  // Task memory ports
  entry_t               mem_q [MAX_TASKS];
  logic                 rd_en;
  logic [SlotW-1:0]     rd_addr;
  logic                 we;
  logic [SlotW-1:0]     waddr;
  entry_t               wdata;

  // Scan helpers
  logic                 ent_ready;
  logic                 scan_last;
  logic [CntW:0]        rem_shift;
  logic [31:0]          slot_wide;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {4'd0, m_start_q, m_slot_q};

  // Read issue: one entry per cycle during either scan pass
  assign rd_en   = ((state_q == ST_SCAN_BEST) || (state_q == ST_SCAN_PICK)) &&
                   (iss_q < NumSlots);
  assign rd_addr = iss_q[SlotW-1:0];

  // Entry just read is ready when valid and already due
  assign ent_ready = rd_vld_q && valid_q[rd_idx_q] && !(rd_data_q.due > now_q);
  assign scan_last = rd_vld_q && (rd_idx_q == LastSlot);
  assign rem_shift = {rem_q, div_q[15]};
  assign slot_wide = {28'd0, in_slot};

  // Next state and datapath control
  always_comb begin
    state_d    = state_q;
    cur_time_d = cur_time_q;
    valid_d    = valid_q;
    now_d      = now_q;
    iss_d      = rd_en ? iss_q + CntW'(1) : iss_q;
    found_d    = found_q;
    best_d     = best_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    div_d      = div_q;
    bit_d      = bit_q;
    seen_d     = seen_q;
    res_kind_d = res_kind_q;
    res_slot_d = res_slot_q;
    m_valid_d  = m_valid_q;
    m_kind_d   = m_kind_q;
    m_slot_d   = m_slot_q;
    m_start_d  = m_start_q;
    we         = 1'b0;
    waddr      = rd_idx_q;
    wdata      = rd_data_q;

    // output register drains on a transaction
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          now_d      = cur_time_q;
          div_d      = in_tie;
          res_slot_d = 4'd0;
          if (s_axis_tuser[0] == OP_LOAD) begin
            res_kind_d = KIND_LOADED;
            if (slot_wide < 32'(MAX_TASKS)) begin
              we             = 1'b1;
              waddr          = SlotW'(in_slot);
              wdata.due      = 32'd0;
              wdata.period   = in_period;
              wdata.duration = in_duration;
              wdata.prio     = in_prio;
              valid_d[SlotW'(in_slot)] = 1'b1;
            end
            state_d = ST_RESULT;
          end else if (cur_time_q >= run_len_q) begin
            res_kind_d = KIND_FINISHED;
            state_d    = ST_RESULT;
          end else begin
            iss_d   = '0;
            found_d = 1'b0;
            best_d  = '0;
            cnt_d   = '0;
            state_d = ST_SCAN_BEST;
          end
        end
      end

      // Pass one: highest priority among ready tasks and its tie count
      ST_SCAN_BEST: begin
        if (ent_ready) begin
          if (!found_q || (rd_data_q.prio > best_q)) begin
            found_d = 1'b1;
            best_d  = rd_data_q.prio;
            cnt_d   = CntW'(1);
          end else if (rd_data_q.prio == best_q) begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
        if (scan_last) begin
          if (!found_d) begin
            cur_time_d = sat_add(now_q, 32'd1);
            res_kind_d = KIND_IDLE;
            state_d    = ST_RESULT;
          end else begin
            rem_d   = '0;
            bit_d   = '0;
            state_d = ST_REMAINDER;
          end
        end
      end

      // tie_pick mod count, one dividend bit per cycle
      ST_REMAINDER: begin
        if (rem_shift >= {1'b0, cnt_q}) begin
          rem_d = CntW'(rem_shift - {1'b0, cnt_q});
        end else begin
          rem_d = CntW'(rem_shift);
        end
        div_d = {div_q[14:0], 1'b0};
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'd15) begin
          iss_d   = '0;
          seen_d  = '0;
          state_d = ST_SCAN_PICK;
        end
      end

      // Pass two: find the picked task among the top-priority ready ones
      ST_SCAN_PICK: begin
        if (ent_ready && (rd_data_q.prio == best_q)) begin
          if (seen_q == rem_q) begin
            we         = 1'b1;
            waddr      = rd_idx_q;
            wdata.due  = sat_add(now_q, {16'd0, rd_data_q.period});
            cur_time_d = sat_add(now_q, {16'd0, rd_data_q.duration});
            res_kind_d = KIND_DISPATCH;
            res_slot_d = 4'(rd_idx_q);
            state_d    = ST_RESULT;
          end else begin
            seen_d = seen_q + CntW'(1);
          end
        end
      end

      // Hand the result to the output register once it is free
      ST_RESULT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_kind_d  = res_kind_q;
          m_slot_d  = res_slot_q;
          m_start_d = now_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      run_len_q  <= RunLengthReset;
      cur_time_q <= '0;
      valid_q    <= '0;
      iss_q      <= '0;
      rd_vld_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_time_q <= cur_time_d;
      valid_q    <= valid_d;
      iss_q      <= iss_d;
      rd_vld_q   <= rd_en;
      m_valid_q  <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        run_len_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    found_q    <= found_d;
    best_q     <= best_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    div_q      <= div_d;
    bit_q      <= bit_d;
    seen_q     <= seen_d;
    res_kind_q <= res_kind_d;
    res_slot_q <= res_slot_d;
    m_kind_q   <= m_kind_d;
    m_slot_q   <= m_slot_d;
    m_start_q  <= m_start_d;
  end

  // Task memory: one write port, one registered read port. A write only
  // happens on a load (no scan running) or on the pick, after which any
  // read still in flight is discarded, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

endmodule

// ===== rtl/ptd_checker.sv =====
// ----------------------------------------------------------------------------
// ptd_checker: port-level assertions for the periodic task dispatcher
// Tracks outstanding transactions and result start times seen on the ports.
// ----------------------------------------------------------------------------
module ptd_checker
  import ptd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  logic        in_acc;
  logic        out_acc;
  logic [1:0]  pend_q;
  logic        seen_q;
  logic [31:0] last_start_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Outstanding items and last reported start time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      seen_q       <= 1'b0;
      last_start_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        seen_q       <= 1'b1;
        last_start_q <= m_axis_tdata[35:4];
      end
    end
  end

  // Every result answers an earlier accepted item
  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != 2'd0))
    else $error("result without a pending item");

  // At most one item in work plus one waiting result
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 2'd0) || (pend_q == 2'd1) || (pend_q == 2'd2))
    else $error("too many items outstanding");

  // Time never runs backwards between results
  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && seen_q) |-> (m_axis_tdata[35:4] >= last_start_q))
    else $error("start time went backwards");

  // Only a dispatch names a slot
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_DISPATCH)) |-> (m_axis_tdata[3:0] == 4'd0))
    else $error("slot set on a non-dispatch result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind periodic_task_dispatcher_core ptd_checker u_ptd_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for periodic_task_dispatcher_core
// Drives load and step transactions into the input stream and keeps its own
// copy of the task table, time and run length. Each result transaction is
// compared field by field against the oldest predicted result. The run
// covers a directed table walk, run length limits, random traffic with
// varied idling on both sides, the run-finished boundary and a long output
// stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top
  import ptd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSlots    = MaxTasksDefault;
  localparam int unsigned SettleWait  = 2 * NumSlots + 21 + 30;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned HoldCycles  = 600;

  typedef struct {
    kind_e       kind;
    logic [3:0]  slot;
    logic [31:0] start;
  } sched_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // task_slot, period, duration, priority_req, tie_pick, zero fill
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // op
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // chosen_slot, start_time, zero fill
  logic [OutDataW-1:0] m_axis_tdata;
  // kind
  logic [1:0]          m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [31:0]         cfg_data_i = '0;

  // Shadow dispatcher state
  logic [31:0] model_time;
  logic [31:0] run_limit;
  logic        task_live [NumSlots];
  logic [31:0] task_due  [NumSlots];
  logic [15:0] task_per  [NumSlots];
  logic [15:0] task_dur  [NumSlots];
  logic [15:0] task_prio [NumSlots];

  sched_result_t pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  logic          hold_active = 1'b0;

  periodic_task_dispatcher_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
    logic [32:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[32] ? '1 : wide[31:0];
  endfunction

  function automatic logic [InDataW-1:0] make_word(logic [3:0] slot, logic [15:0] per,
                                                   logic [15:0] dur, logic [15:0] prio,
                                                   logic [15:0] tie);
    return {4'd0, tie, prio, dur, per, slot};
  endfunction

  // Apply one accepted transaction to the shadow state, return its result
  function automatic sched_result_t predict_dispatch(op_e op, logic [InDataW-1:0] word);
    sched_result_t res;
    logic [3:0]    slot;
    logic          any_ready;
    logic [15:0]   top_prio;
    int unsigned   tied;
    int unsigned   pick;
    int unsigned   seen;
    int unsigned   winner;
    res.kind  = KIND_LOADED;
    res.slot  = '0;
    res.start = model_time;
    slot      = word[3:0];
    if (op == OP_LOAD) begin
      task_per[slot]  = word[19:4];
      task_dur[slot]  = word[35:20];
      task_prio[slot] = word[51:36];
      task_due[slot]  = '0;
      task_live[slot] = 1'b1;
      return res;
    end
    if (model_time >= run_limit) begin
      res.kind = KIND_FINISHED;
      return res;
    end
    // best priority among ready slots and how many share it
    any_ready = 1'b0;
    top_prio  = '0;
    tied      = 0;
    for (int i = 0; i < NumSlots; i++) begin
      if (task_live[i] && task_due[i] <= model_time) begin
        if (!any_ready || task_prio[i] > top_prio) begin
          any_ready = 1'b1;
          top_prio  = task_prio[i];
          tied      = 1;
        end else if (task_prio[i] == top_prio) begin
          tied++;
        end
      end
    end
    if (!any_ready) begin
      res.kind   = KIND_IDLE;
      model_time = add_clamped(model_time, 32'd1);
      return res;
    end
    // pick-th tied slot in slot order
    pick   = int'(word[67:52]) % tied;
    seen   = 0;
    winner = 0;
    for (int i = 0; i < NumSlots; i++) begin
      if (task_live[i] && task_due[i] <= model_time && task_prio[i] == top_prio) begin
        if (seen == pick) winner = i;
        seen++;
      end
    end
    task_due[winner] = add_clamped(model_time, {16'd0, task_per[winner]});
    res.kind   = KIND_DISPATCH;
    res.slot   = winner[3:0];
    res.start  = model_time;
    model_time = add_clamped(model_time, {16'd0, task_dur[winner]});
    return res;
  endfunction

  // Result checker and output ready generation
  always @(posedge clk_i) begin
    sched_result_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d slot %0d start %0d", $time,
                   m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4]);
          mismatch_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (m_axis_tuser !== exp_res.kind || m_axis_tdata[3:0] !== exp_res.slot ||
              m_axis_tdata[35:4] !== exp_res.start) begin
            $display("%0t: expected kind %0d slot %0d start %0d, got kind %0d slot %0d start %0d",
                     $time, exp_res.kind, exp_res.slot, exp_res.start,
                     m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4]);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One input transaction; valid stays up unless a gap is drawn
  task automatic send_item(input op_e op, input logic [InDataW-1:0] word);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), predict_dispatch(op, word));
  endtask

  // Let the block go idle: all results in, then the step latency
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_run_length(input logic [31:0] value);
    wait_until_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    run_limit = value;
  endtask

  task automatic send_step(input logic [15:0] tie);
    send_item(OP_STEP, make_word(4'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), tie));
  endtask

  task automatic send_load(input logic [3:0] slot, input logic [15:0] per,
                           input logic [15:0] dur, input logic [15:0] prio);
    send_item(OP_LOAD, make_word(slot, per, dur, prio, 16'($urandom)));
  endtask

  // Mostly small periods, durations and priorities so ties and idle ticks occur
  task automatic send_random_item();
    logic [15:0] per;
    logic [15:0] dur;
    logic [15:0] prio;
    if ($urandom_range(99) < 20) begin
      per  = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 1))
                                      : 16'($urandom_range(40, 1));
      dur  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      prio = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      send_load(4'($urandom), per, dur, prio);
    end else begin
      send_step(16'($urandom));
    end
  endtask

  task automatic run_random_phase(input int unsigned n_items, input int unsigned send_pct,
                                  input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    repeat (n_items) send_random_item();
    wait_until_drained();
  endtask

  // Table walk under the reset run length: ties, reload, zero and full duration
  task automatic test_directed_table();
    send_step(16'd0);
    send_load(4'd15, 16'd1, 16'd0, 16'd0);
    send_load(4'd3, 16'd5, 16'd2, 16'd7);
    send_load(4'd9, 16'd5, 16'd2, 16'd7);
    send_load(4'd12, 16'd3, 16'd1, 16'd7);
    send_step(16'd0);
    send_step(16'hFFFF);
    send_step(16'd2);
    send_item(OP_STEP, make_word(4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1));
    send_step(16'd0);
    send_step(16'd5);
    // reload: back to due at zero with new values
    send_load(4'd3, 16'hFFFF, 16'd0, 16'hFFFF);
    send_step(16'd0);
    send_step(16'd1);
    send_step(16'd3);
    send_load(4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_step(16'd0);
    send_step(16'hFFFF);
    send_step(16'd0);
    send_step(16'd0);
    wait_until_drained();
  endtask

  // Zero length run finishes at once; full length never does
  task automatic test_run_length_limits();
    write_run_length(32'd0);
    send_step(16'd0);
    send_load(4'd7, 16'd2, 16'd1, 16'd1);
    send_step(16'd3);
    write_run_length(32'hFFFF_FFFF);
    send_step(16'd0);
    send_step(16'd1);
    wait_until_drained();
  endtask

  task automatic test_random_traffic();
    run_random_phase(200, 0, 0);
    run_random_phase(200, 75, 0);
    run_random_phase(200, 0, 75);
    run_random_phase(220, 17, 17);
  endtask

  // Run length just ahead of current time so steps cross into finished
  task automatic test_finish_boundary();
    wait_until_drained();
    write_run_length(model_time + 32'd150);
    run_random_phase(100, 30, 30);
    write_run_length(model_time);
    send_step(16'd0);
    write_run_length(32'hFFFF_FFFF);
  endtask

  // Output held off for a long stretch while inputs keep coming
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active <= 1'b0;
      end
    join_none
    repeat (40) send_random_item();
    wait_until_drained();
  endtask

  initial begin
    model_time = '0;
    run_limit  = RunLengthReset;
    for (int i = 0; i < NumSlots; i++) begin
      task_live[i] = 1'b0;
      task_due[i]  = '0;
      task_per[i]  = '0;
      task_dur[i]  = '0;
      task_prio[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_table();
    test_run_length_limits();
    test_random_traffic();
    test_finish_boundary();
    test_output_backpressure();

    wait_until_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ptd_pkg.sv
rtl/periodic_task_dispatcher_core.sv
rtl/ptd_checker.sv
bench/tb_top.sv
